// ----- hdl/wsfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the WebSocket frame parser.
// No dependencies; every other file of the parser imports this package.
package wsfp_pkg;

	localparam int LenW    = 25;
	localparam int QDepth  = 2;
	localparam int QAddrW  = $clog2(QDepth);
	localparam int QCountW = $clog2(QDepth + 1);

	localparam logic [LenW-1:0] MaxLenReset = LenW'(1024 * 1024);

	localparam logic [3:0] OpText   = 4'h1;
	localparam logic [3:0] OpBinary = 4'h2;
	localparam logic [3:0] OpClose  = 4'h8;
	localparam logic [3:0] OpPing   = 4'h9;

	localparam logic [6:0] Len16Code = 7'd126;
	localparam logic [6:0] Len64Code = 7'd127;

	localparam logic [3:0] ExtBytes16 = 4'd2;
	localparam logic [3:0] ExtBytes64 = 4'd8;
	localparam logic [2:0] KeyBytes   = 3'd4;

	typedef enum logic [1:0] {
		EV_BYTE  = 2'd0,
		EV_EMPTY = 2'd1,
		EV_CLOSE = 2'd2,
		EV_ERROR = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_KEY,
		PH_DATA,
		PH_STOP
	} phase_t;

	// One result in flight between the front and the back.
	typedef struct packed {
		event_t     ev;
		logic [3:0] opcode;
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
	} cmd_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic emits_bytes(input logic [3:0] op);
		return (op == OpText) || (op == OpBinary) || (op == OpPing);
	endfunction

endpackage

// ----- hdl/wsfp_front.sv -----
`timescale 1ns / 1ps
// Front part: accepts received bytes, tracks the frame header and turns each
// byte into a result command or nothing. Depends on wsfp_pkg.
module wsfp_front import wsfp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [LenW-1:0] cfg_wr_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      rx_byte,
	input  q_status_t       q_status,
	output logic            push,
	output cmd_t            push_cmd
);

	phase_t          phase_q, phase_d;
	logic [3:0]      opcode_q, opcode_d;
	logic            mask_q, mask_d;
	logic [3:0]      ext_left_q, ext_left_d;
	logic [LenW-1:0] len_q, len_d;
	logic            over_q, over_d;
	logic [31:0]     key_q, key_d;
	logic [2:0]      key_cnt_q, key_cnt_d;
	logic [LenW-1:0] remain_q, remain_d;
	logic [1:0]      kidx_q, kidx_d;
	logic [LenW-1:0] max_len_q;

	logic            accept;
	logic            hdr_done;
	logic [LenW-1:0] len_chk;
	logic            over_chk;
	logic            data_last;
	logic [7:0]      key_byte;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign data_last = (remain_q <= LenW'(1));

	always_comb begin
		phase_d    = phase_q;
		opcode_d   = opcode_q;
		mask_d     = mask_q;
		ext_left_d = ext_left_q;
		len_d      = len_q;
		over_d     = over_q;
		key_d      = key_q;
		key_cnt_d  = key_cnt_q;
		remain_d   = remain_q;
		kidx_d     = kidx_q;
		hdr_done   = 1'b0;
		len_chk    = len_q;
		over_chk   = over_q;
		push       = 1'b0;
		push_cmd   = '{ev: EV_BYTE, opcode: opcode_q, data: 8'd0, key: 8'd0, last: 1'b1};

		if (accept) begin
			case (phase_q)
				PH_HDR0: begin
					opcode_d   = rx_byte[3:0];
					mask_d     = 1'b0;
					key_d      = '0;
					key_cnt_d  = '0;
					len_d      = '0;
					over_d     = 1'b0;
					ext_left_d = '0;
					phase_d    = PH_HDR1;
				end
				PH_HDR1: begin
					mask_d = rx_byte[7];
					if (rx_byte[6:0] == Len16Code) begin
						ext_left_d = ExtBytes16;
						phase_d    = PH_EXT;
					end else if (rx_byte[6:0] == Len64Code) begin
						ext_left_d = ExtBytes64;
						phase_d    = PH_EXT;
					end else begin
						len_d    = LenW'(rx_byte[6:0]);
						over_d   = 1'b0;
						len_chk  = LenW'(rx_byte[6:0]);
						over_chk = 1'b0;
						if (rx_byte[7]) begin
							phase_d = PH_KEY;
						end else begin
							hdr_done = 1'b1;
						end
					end
				end
				PH_EXT: begin
					// Bits shifted past the top of the length register make it sticky-large.
					over_d     = over_q || (len_q[LenW-1:LenW-8] != 8'd0);
					len_d      = {len_q[LenW-9:0], rx_byte};
					ext_left_d = ext_left_q - 4'd1;
					len_chk    = len_d;
					over_chk   = over_d;
					if (ext_left_q == 4'd1) begin
						if (mask_q) begin
							phase_d = PH_KEY;
						end else begin
							hdr_done = 1'b1;
						end
					end
				end
				PH_KEY: begin
					key_d     = {key_q[23:0], rx_byte};
					key_cnt_d = key_cnt_q + 3'd1;
					if (key_cnt_d == KeyBytes) begin
						hdr_done = 1'b1;
					end
				end
				PH_DATA: begin
					kidx_d   = kidx_q + 2'd1;
					remain_d = data_last ? '0 : remain_q - LenW'(1);
					if (data_last) begin
						phase_d = PH_HDR0;
					end
					if (opcode_q == OpClose) begin
						if (data_last) begin
							phase_d     = PH_STOP;
							push        = 1'b1;
							push_cmd.ev = EV_CLOSE;
						end
					end else if (emits_bytes(opcode_q)) begin
						push          = 1'b1;
						push_cmd.data = rx_byte;
						push_cmd.key  = key_byte;
						push_cmd.last = data_last;
					end
				end
				default: begin
				end
			endcase

			if (hdr_done) begin
				if (over_chk || (len_chk > max_len_q)) begin
					phase_d     = PH_STOP;
					push        = 1'b1;
					push_cmd.ev = EV_ERROR;
				end else if (len_chk == '0) begin
					phase_d = PH_HDR0;
					if (opcode_q == OpClose) begin
						phase_d     = PH_STOP;
						push        = 1'b1;
						push_cmd.ev = EV_CLOSE;
					end else if (emits_bytes(opcode_q)) begin
						push        = 1'b1;
						push_cmd.ev = EV_EMPTY;
					end
				end else begin
					remain_d = len_chk;
					kidx_d   = '0;
					phase_d  = PH_DATA;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			opcode_q   <= '0;
			mask_q     <= 1'b0;
			ext_left_q <= '0;
			len_q      <= '0;
			over_q     <= 1'b0;
			key_q      <= '0;
			key_cnt_q  <= '0;
			remain_q   <= '0;
			kidx_q     <= '0;
			max_len_q  <= MaxLenReset;
		end else begin
			phase_q    <= phase_d;
			opcode_q   <= opcode_d;
			mask_q     <= mask_d;
			ext_left_q <= ext_left_d;
			len_q      <= len_d;
			over_q     <= over_d;
			key_q      <= key_d;
			key_cnt_q  <= key_cnt_d;
			remain_q   <= remain_d;
			kidx_q     <= kidx_d;
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
		end
	end

	// Once stopped, the parser stays stopped until reset.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STOP) |=> (phase_q == PH_STOP))
		else $error("parser left the stopped phase");

	// A frame in its payload always has bytes left to consume.
	a_data_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (remain_q != '0))
		else $error("payload phase with no bytes remaining");

	// Events other than payload bytes always close their frame.
	a_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (push_cmd.ev != EV_BYTE)) |-> push_cmd.last)
		else $error("frame event without last flag");

endmodule

// ----- hdl/wsfp_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the parser front and the output back.
// Depends on wsfp_pkg for the command type and depth.
module wsfp_queue import wsfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t status
);

	cmd_t               mem_q [QDepth];
	logic [QAddrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCountW-1:0] count_q;

	assign status.full  = (count_q == QCountW'(QDepth));
	assign status.empty = (count_q == '0);
	assign pop_cmd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAddrW'(QDepth - 1)) ? '0 : wr_ptr_q + QAddrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAddrW'(QDepth - 1)) ? '0 : rd_ptr_q + QAddrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCountW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCountW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!status.full || pop))
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from an empty queue");

	a_count_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - QCountW'(1)))
		else $error("queue count did not drop after pop");

endmodule

// ----- hdl/wsfp_back.sv -----
`timescale 1ns / 1ps
// Back part: takes commands from the queue, unmasks payload bytes and holds
// the result in the output register. Depends on wsfp_pkg.
module wsfp_back import wsfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_status_t  q_status,
	input  cmd_t       pop_cmd,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] event_res,
	output logic [3:0] frame_opcode,
	output logic [7:0] payload_byte,
	output logic       last_of_frame
);

	logic       valid_q;
	logic [1:0] event_q;
	logic [3:0] opcode_q;
	logic [7:0] byte_q;
	logic       last_q;

	assign pop = !q_status.empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			event_q  <= pop_cmd.ev;
			opcode_q <= pop_cmd.opcode;
			byte_q   <= pop_cmd.data ^ pop_cmd.key;
			last_q   <= pop_cmd.last;
		end
	end

	assign out_valid     = valid_q;
	assign event_res     = event_q;
	assign frame_opcode  = opcode_q;
	assign payload_byte  = byte_q;
	assign last_of_frame = last_q;

endmodule

// ----- hdl/websocket_frame_parser.sv -----
`timescale 1ns / 1ps
// WebSocket frame parser top level. The edge that accepts a byte writes its result into
// the queue; the output register loads it from the queue once the register is free, and
// out_valid rises with that load. Throughput: one byte per clock; the input stalls only
// while the two-entry queue is full because the output is held off.
// Reset (arst_n, asynchronous, active low) returns the parser to the first header
// byte, empties the queue and the output register, and restores the length limit to 1 MiB.
module websocket_frame_parser import wsfp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [LenW-1:0] cfg_wr_data,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      rx_byte,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      event_res,
	output logic [3:0]      frame_opcode,
	output logic [7:0]      payload_byte,
	output logic            last_of_frame
);

	// The front parses the byte stream and pushes one command per result.
	// A command carries the raw byte and the selected mask key byte; the XOR
	// itself is done by the back when the command moves into the output register.
	q_status_t q_status;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      pop_cmd;

	// Header parsing, length check and frame classification. The front stalls
	// the input only when the queue is full, so it keeps taking bytes while a
	// finished result still waits at the output.
	wsfp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.q_status    (q_status),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// Decouples the two sides so each can stall on its own.
	wsfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (q_status)
	);

	// Unmasking and the output register; a new result loads whenever the
	// register is empty or its current transaction completes.
	wsfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.pop_cmd       (pop_cmd),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_res     (event_res),
		.frame_opcode  (frame_opcode),
		.payload_byte  (payload_byte),
		.last_of_frame (last_of_frame)
	);

endmodule
